@@ rtl/pif_pkg.sv @@
// Shared types and constants for the polyphase interpolation FIR core.
// No dependencies; the core, pif_seq and pif_mac import this package.
`timescale 1ns / 1ps

package pif_pkg;

    // fixed field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int PHASES_W     = 4;
    localparam int TAPS_W       = 5;
    localparam int COEF_IDX_W   = 7;
    localparam int PHASE_IDX_W  = 3;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_PHASES = 1'b0;
    localparam logic CFG_IDX_TAPS   = 1'b1;

    localparam logic [PHASES_W-1:0] PHASES_RESET = 4'd2;
    localparam logic [TAPS_W-1:0]   TAPS_RESET   = 5'd16;

    // item kind
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    typedef struct packed {
        logic                           func;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic [COEF_IDX_W-1:0]          coef_index;
        logic signed [SAMPLE_WIDTH-1:0] coef_value;
    } pif_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic [PHASE_IDX_W-1:0]         phase_index;
        logic                           last;
    } pif_out_t;

    // one tap issued by the sequencer, travels down the mac pipeline
    typedef struct packed {
        logic                   valid;
        logic                   first;
        logic                   last_tap;
        logic                   last_phase;
        logic [PHASE_IDX_W-1:0] phase;
    } pif_tap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } pif_state_t;

endpackage

@@ rtl/polyphase_interpolation_fir_core.sv @@
// Polyphase FIR interpolator: top level with config registers, coefficient
// and delay memories, sequencer, mac unit and output register.
// Depends on pif_pkg, pif_ram, pif_seq, pif_mac.
//
// Input channel (in_valid / in_stall / in_data): a transfer with func set
// writes one coefficient if coef_index is below DEPTH. A transfer with func
// clear pushes a sample into the delay line and produces one output
// transfer per phase, phase 0 first, last set on the final phase.
// Output channel (out_valid / out_stall / out_data) is fed by a one-entry
// output register, so a new input is taken while the last result waits.
// One shared 16x16 multiplier does every tap: each phase runs the tap loop
// and then the ram read, product and accumulate stages.
// A stalled output holds the mac result and pauses the tap loop; in_stall
// stays high until the final result of the sample is in the output register.
// Reset clears the delay line (per-entry valid bits), the write pointer
// and sets phases to 2 and taps_per_phase to 16; coefficients are
// undefined until written. Config writes over APB, pready always high.
`timescale 1ns / 1ps

module polyphase_interpolation_fir_core #(
    parameter int MAX_PHASES         = 8,
    parameter int MAX_TAPS_PER_PHASE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pif_pkg::pif_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pif_pkg::pif_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pif_pkg::PADDR_W-1:0]   paddr,
    input  logic [pif_pkg::PDATA_W-1:0]   pwdata,
    output logic [pif_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import pif_pkg::*;

    localparam int DEPTH = MAX_PHASES * MAX_TAPS_PER_PHASE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DAW   = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;

    logic [PHASES_W-1:0]     phases_reg, phases_next;
    logic [TAPS_W-1:0]       taps_reg, taps_next;
    logic [MAX_TAPS_PER_PHASE-1:0] dvalid_reg, dvalid_next;
    logic                    dvalid_q_reg, dvalid_q_next;
    logic                    out_valid_reg, out_valid_next;
    pif_out_t                out_data_reg, out_data_next;

    logic                    cfg_wr;
    logic                    in_fire;
    logic                    seq_idle;
    logic                    coef_we;
    logic                    dly_we;
    logic [DAW-1:0]          wr_ptr;
    logic [AW-1:0]           coef_raddr;
    logic [DAW-1:0]          dly_raddr;
    logic [SAMPLE_WIDTH-1:0] coef_q;
    logic [SAMPLE_WIDTH-1:0] dly_q;
    logic signed [SAMPLE_WIDTH-1:0] dly_data;
    pif_tap_t                issue;
    logic                    res_valid;
    pif_out_t                res;
    logic                    load;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        phases_next = phases_reg;
        taps_next   = taps_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                CFG_IDX_PHASES: phases_next = pwdata[PHASES_W-1:0];
                CFG_IDX_TAPS:   taps_next   = pwdata[TAPS_W-1:0];
                default:        phases_next = phases_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            CFG_IDX_PHASES: prdata = PDATA_W'(phases_reg);
            CFG_IDX_TAPS:   prdata = PDATA_W'(taps_reg);
            default:        prdata = '0;
        endcase
    end

    // input transfer and memory writes
    assign in_stall = !seq_idle;
    assign in_fire  = in_valid && !in_stall;
    assign coef_we  = in_fire && (in_data.func == FUNC_COEF)
                      && (32'(in_data.coef_index) < DEPTH);
    assign dly_we   = in_fire && (in_data.func == FUNC_SAMPLE);

    pif_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (AW'(in_data.coef_index)),
        .wdata (in_data.coef_value),
        .raddr (coef_raddr),
        .rdata (coef_q)
    );

    pif_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_TAPS_PER_PHASE)
    ) u_dly_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (wr_ptr),
        .wdata (in_data.sample_in),
        .raddr (dly_raddr),
        .rdata (dly_q)
    );

    // delay entries never written read as zero
    always_comb
    begin
        dvalid_next = dvalid_reg;
        if (dly_we)
        begin
            dvalid_next[wr_ptr] = 1'b1;
        end
        dvalid_q_next = dvalid_reg[dly_raddr];
    end

    assign dly_data = dvalid_q_reg ? $signed(dly_q) : '0;

    pif_seq #(
        .MAX_PHASES         (MAX_PHASES),
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dly_we),
        .phases     (phases_reg),
        .taps       (taps_reg),
        .load       (load),
        .idle       (seq_idle),
        .wr_ptr     (wr_ptr),
        .coef_raddr (coef_raddr),
        .dly_raddr  (dly_raddr),
        .issue      (issue)
    );

    pif_mac #(
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .coef_data ($signed(coef_q)),
        .dly_data  (dly_data),
        .load      (load),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    assign load = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = load || (out_valid_reg && out_stall);
        out_data_next  = load ? res : out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phases_reg    <= PHASES_RESET;
            taps_reg      <= TAPS_RESET;
            dvalid_reg    <= '0;
            dvalid_q_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phases_reg    <= phases_next;
            taps_reg      <= taps_next;
            dvalid_reg    <= dvalid_next;
            dvalid_q_reg  <= dvalid_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no new item while a mac result is still pending
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !res_valid)
        else $error("input accepted with a mac result pending");

    // the final phase of a sample frees the input side next cycle
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res.last) |=> seq_idle)
        else $error("sequencer busy after last phase");

    // delay entries, once written, stay valid
    a_dvalid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (dvalid_reg & $past(dvalid_reg)) == $past(dvalid_reg))
        else $error("delay valid bit cleared");

endmodule

@@ rtl/pif_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pif_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pif_mac.sv @@
// Shared multiply-accumulate unit: product register, wide accumulator,
// round, shift and saturate. Depends on pif_pkg.
`timescale 1ns / 1ps

module pif_mac #(
    parameter int MAX_TAPS_PER_PHASE = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pif_pkg::pif_tap_t                       issue,
    input  logic signed [pif_pkg::SAMPLE_WIDTH-1:0] coef_data,
    input  logic signed [pif_pkg::SAMPLE_WIDTH-1:0] dly_data,
    input  logic                                    load,
    output logic                                    res_valid,
    output pif_pkg::pif_out_t                       res
);

    import pif_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int ACC_W = 2 * SW + $clog2(MAX_TAPS_PER_PHASE) + 1;
    localparam int FRAC  = SW - 1;

    localparam logic signed [ACC_W-1:0] ROUND_C =
        {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

    pif_tap_t                s1_reg, s1_next;
    pif_tap_t                s2_reg, s2_next;
    logic signed [2*SW-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    res_valid_reg, res_valid_next;
    logic [PHASE_IDX_W-1:0]  res_phase_reg, res_phase_next;
    logic                    res_last_reg, res_last_next;

    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] sat_val;

    // pipeline: s1 aligns with ram data, s2 with the product
    always_comb
    begin
        s1_next   = issue;
        s2_next   = s1_reg;
        prod_next = prod_reg;
        if (s1_reg.valid)
        begin
            prod_next = coef_data * dly_data;
        end
    end

    // accumulate, rounding constant seeded on the first tap
    always_comb
    begin
        acc_base       = s2_reg.first ? ROUND_C : acc_reg;
        prod_ext       = $signed({{(ACC_W - 2 * SW){prod_reg[2*SW-1]}}, prod_reg});
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        res_phase_next = res_phase_reg;
        res_last_next  = res_last_reg;
        if (load)
        begin
            res_valid_next = 1'b0;
        end
        if (s2_reg.valid)
        begin
            acc_next = acc_base + prod_ext;
            if (s2_reg.last_tap)
            begin
                res_valid_next = 1'b1;
                res_phase_next = s2_reg.phase;
                res_last_next  = s2_reg.last_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        res_phase_reg <= res_phase_next;
        res_last_reg  <= res_last_next;
    end

    // shift out the fraction and saturate
    always_comb
    begin
        shifted = acc_reg >>> FRAC;
        if (shifted > SAT_HI)
        begin
            sat_val = SAT_HI;
        end
        else if (shifted < SAT_LO)
        begin
            sat_val = SAT_LO;
        end
        else
        begin
            sat_val = shifted;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res.sample_out  = sat_val[SW-1:0];
    assign res.phase_index = res_phase_reg;
    assign res.last        = res_last_reg;

endmodule

@@ rtl/pif_seq.sv @@
// Sequencer: write pointer, phase and tap counters, ram read addresses.
// Issues one tap per cycle, waiting for load after each phase. Uses pif_pkg.
`timescale 1ns / 1ps

module pif_seq #(
    parameter int MAX_PHASES         = 8,
    parameter int MAX_TAPS_PER_PHASE = 16,
    parameter int AW  = ((MAX_PHASES * MAX_TAPS_PER_PHASE) > 1) ?
                        $clog2(MAX_PHASES * MAX_TAPS_PER_PHASE) : 1,
    parameter int DAW = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pif_pkg::PHASES_W-1:0]   phases,
    input  logic [pif_pkg::TAPS_W-1:0]     taps,
    input  logic                           load,
    output logic                           idle,
    output logic [DAW-1:0]                 wr_ptr,
    output logic [AW-1:0]                  coef_raddr,
    output logic [DAW-1:0]                 dly_raddr,
    output pif_pkg::pif_tap_t              issue
);

    import pif_pkg::*;

    localparam int PEW = $clog2(MAX_PHASES + 1);
    localparam int TEW = $clog2(MAX_TAPS_PER_PHASE + 1);
    localparam logic [DAW-1:0] DLY_TOP = DAW'(MAX_TAPS_PER_PHASE - 1);

    pif_state_t     state_reg, state_next;
    logic [DAW-1:0] wp_reg, wp_next;
    logic [PEW-1:0] phase_reg, phase_next;
    logic [TEW-1:0] tap_reg, tap_next;
    logic [AW-1:0]  caddr_reg, caddr_next;
    logic [DAW-1:0] daddr_reg, daddr_next;

    logic [PEW-1:0] phases_eff;
    logic [TEW-1:0] taps_eff;
    logic [DAW-1:0] wp_dec;
    logic           last_tap;
    logic           last_phase;

    // clamp the register values into the supported range
    always_comb
    begin
        if (phases == '0)
        begin
            phases_eff = PEW'(1);
        end
        else if (32'(phases) > MAX_PHASES)
        begin
            phases_eff = PEW'(MAX_PHASES);
        end
        else
        begin
            phases_eff = PEW'(phases);
        end

        if (taps == '0)
        begin
            taps_eff = TEW'(1);
        end
        else if (32'(taps) > MAX_TAPS_PER_PHASE)
        begin
            taps_eff = TEW'(MAX_TAPS_PER_PHASE);
        end
        else
        begin
            taps_eff = TEW'(taps);
        end
    end

    assign wp_dec     = (wp_reg == '0) ? DLY_TOP : wp_reg - DAW'(1);
    assign last_tap   = (tap_reg == taps_eff - TEW'(1));
    assign last_phase = (phase_reg == phases_eff - PEW'(1));

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        phase_next = phase_reg;
        tap_next   = tap_reg;
        caddr_next = caddr_reg;
        daddr_next = daddr_reg;

        idle             = 1'b0;
        issue.valid      = 1'b0;
        issue.first      = (tap_reg == '0);
        issue.last_tap   = last_tap;
        issue.last_phase = last_phase;
        issue.phase      = PHASE_IDX_W'(phase_reg);

        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    wp_next    = wp_dec;
                    phase_next = '0;
                    tap_next   = '0;
                    caddr_next = '0;
                    daddr_next = wp_dec;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                issue.valid = 1'b1;
                tap_next    = tap_reg + TEW'(1);
                caddr_next  = caddr_reg + AW'(phases_eff);
                daddr_next  = (daddr_reg == DLY_TOP) ? '0 : daddr_reg + DAW'(1);
                if (last_tap)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // result of this phase handed to the output register
                if (load)
                begin
                    if (last_phase)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg + PEW'(1);
                        tap_next   = '0;
                        caddr_next = AW'(phase_reg + PEW'(1));
                        daddr_next = wp_reg;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            phase_reg <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        caddr_reg <= caddr_next;
        daddr_reg <= daddr_next;
    end

    assign wr_ptr     = wp_dec;
    assign coef_raddr = caddr_reg;
    assign dly_raddr  = daddr_reg;

endmodule
